### rtl/tlex_pkg.sv
// Shared types, constants and helpers for the token lexer.
// No dependencies; the RTL uses it through scoped names, the bench imports it.
package tlex_pkg;

  localparam int unsigned POS_WIDTH    = 16;
  localparam int unsigned OFFSET_WIDTH = 32;
  localparam int unsigned LEN_WIDTH    = 16;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned PTR_W        = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W        = $clog2(FIFO_DEPTH + 1);

  typedef logic [7:0]              byte_t;
  typedef logic [POS_WIDTH-1:0]    pos_t;
  typedef logic [OFFSET_WIDTH-1:0] off_t;
  typedef logic [LEN_WIDTH-1:0]    len_t;

  localparam pos_t POS_MAX = {POS_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    KIND_LPAREN  = 4'd0,
    KIND_RPAREN  = 4'd1,
    KIND_LBRACE  = 4'd2,
    KIND_RBRACE  = 4'd3,
    KIND_COMMA   = 4'd4,
    KIND_SEMI    = 4'd5,
    KIND_PIPE    = 4'd6,
    KIND_EQUAL   = 4'd7,
    KIND_IDENT   = 4'd8,
    KIND_EOF     = 4'd9,
    KIND_ILLEGAL = 4'd10
  } kind_e;

  localparam byte_t CH_LPAREN = 8'h28;
  localparam byte_t CH_RPAREN = 8'h29;
  localparam byte_t CH_LBRACE = 8'h7B;
  localparam byte_t CH_RBRACE = 8'h7D;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_SEMI   = 8'h3B;
  localparam byte_t CH_PIPE   = 8'h7C;
  localparam byte_t CH_EQUAL  = 8'h3D;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_SPACE  = 8'h20;
  localparam byte_t CH_LA     = 8'h61;
  localparam byte_t CH_LZ     = 8'h7A;
  localparam byte_t CH_UA     = 8'h41;
  localparam byte_t CH_UZ     = 8'h5A;
  localparam byte_t CH_D0     = 8'h30;
  localparam byte_t CH_D9     = 8'h39;

  typedef struct packed {
    kind_e kind;
    pos_t  line;
    pos_t  column;
    off_t  offset;
    len_t  length;
    logic  last;
  } token_t;

  // Up to two tokens per input item, slot 0 first.
  typedef struct packed {
    token_t     tok0;
    token_t     tok1;
    logic [1:0] count;
  } tok_pair_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             room2;
  } fifo_stat_t;

  function automatic pos_t sat_inc(pos_t v);
    return (v == POS_MAX) ? v : v + pos_t'(1);
  endfunction

  function automatic logic is_alnum(byte_t b);
    return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ) ||
           (b >= CH_D0 && b <= CH_D9);
  endfunction

  function automatic logic is_space(byte_t b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic kind_e punct_kind(byte_t b);
    kind_e k;
    unique case (b)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_COMMA:  k = KIND_COMMA;
      CH_SEMI:   k = KIND_SEMI;
      CH_PIPE:   k = KIND_PIPE;
      CH_EQUAL:  k = KIND_EQUAL;
      default:   k = KIND_ILLEGAL;
    endcase
    return k;
  endfunction

endpackage

### rtl/token_lexer_top.sv
// Token lexer top level: input register, lexer core and result queue.
// Depends on tlex_pkg, tlex_core and tlex_fifo.

// Streaming lexer: one text byte per input item, tokens out with line,
// column, offset and length of their start. A byte is registered on accept,
// classified against the lexer state once the queue has room for two tokens,
// and its tokens (none, one or two) land in a four-entry result queue; the
// first token is visible once it is written there. A byte is accepted every
// cycle while the queue has room for two tokens, so input runs at one item
// per cycle as long as the output drains; bytes that produce two tokens
// (an identifier flushed by a punctuation or illegal byte or end of input)
// are limited by the single output port of the queue, one token per cycle.
module token_lexer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_line_o,
  output logic [15:0] token_column_o,
  output logic [31:0] token_offset_o,
  output logic [15:0] token_length_o,
  output logic        last_result_o
);

  logic                 in_vld_q;
  tlex_pkg::byte_t      data_q;
  logic                 end_q;
  logic                 advance;
  tlex_pkg::tok_pair_t  pair;
  tlex_pkg::token_t     head;
  tlex_pkg::fifo_stat_t stat;

  assign advance    = in_vld_q && stat.room2;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_byte_i;
      end_q  <= end_of_input_i;
    end
  end

  tlex_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (advance),
    .data_byte_i    (data_q),
    .end_of_input_i (end_q),
    .pair_o         (pair)
  );

  tlex_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (advance),
    .pair_i (pair),
    .pop_i  (out_ready_i),
    .head_o (head),
    .stat_o (stat)
  );

  assign out_valid_o    = (stat.count != '0);
  assign token_kind_o   = head.kind;
  assign token_line_o   = head.line;
  assign token_column_o = head.column;
  assign token_offset_o = head.offset;
  assign token_length_o = head.length;
  assign last_result_o  = head.last;

`ifndef SYNTH
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= tlex_pkg::CNT_W'(tlex_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_vld_q)
    else $error("accepted item not held in input register");

  a_eof_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && head.kind == tlex_pkg::KIND_EOF |-> head.last)
    else $error("EOF token not marked last");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> stat.count + tlex_pkg::CNT_W'(pair.count)
                <= tlex_pkg::CNT_W'(tlex_pkg::FIFO_DEPTH))
    else $error("push without room");
`endif

endmodule

### rtl/tlex_core.sv
// Lexer state and per-byte classification: builds up to two tokens per byte.
// Depends on tlex_pkg.
module tlex_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  tlex_pkg::byte_t     data_byte_i,
  input  logic                end_of_input_i,
  output tlex_pkg::tok_pair_t pair_o
);

  logic            in_id_q, in_id_d;
  tlex_pkg::pos_t  id_len_q, id_len_d;
  tlex_pkg::pos_t  id_line_q, id_line_d;
  tlex_pkg::pos_t  id_col_q, id_col_d;
  tlex_pkg::off_t  id_off_q, id_off_d;
  tlex_pkg::pos_t  cur_line_q, cur_line_d;
  tlex_pkg::pos_t  cur_col_q, cur_col_d;
  tlex_pkg::off_t  byte_off_q, byte_off_d;

  tlex_pkg::pos_t  col;
  logic            alnum, space, has_id, has_byte;
  tlex_pkg::token_t id_tok, byte_tok;

  always_comb begin
    col      = tlex_pkg::sat_inc(cur_col_q);
    alnum    = tlex_pkg::is_alnum(data_byte_i);
    space    = tlex_pkg::is_space(data_byte_i);
    has_id   = in_id_q && (end_of_input_i || !alnum);
    has_byte = end_of_input_i || (!alnum && !space);

    id_tok.kind   = tlex_pkg::KIND_IDENT;
    id_tok.line   = id_line_q;
    id_tok.column = id_col_q;
    id_tok.offset = id_off_q;
    id_tok.length = tlex_pkg::len_t'(id_len_q);
    id_tok.last   = !has_byte;

    byte_tok.kind   = end_of_input_i ? tlex_pkg::KIND_EOF
                                     : tlex_pkg::punct_kind(data_byte_i);
    byte_tok.line   = cur_line_q;
    byte_tok.column = col;
    byte_tok.offset = byte_off_q;
    byte_tok.length = tlex_pkg::len_t'(1);
    byte_tok.last   = 1'b1;

    pair_o.tok0  = has_id ? id_tok : byte_tok;
    pair_o.tok1  = byte_tok;
    pair_o.count = {1'b0, has_id} + {1'b0, has_byte};

    // next state
    in_id_d    = in_id_q;
    id_len_d   = id_len_q;
    id_line_d  = id_line_q;
    id_col_d   = id_col_q;
    id_off_d   = id_off_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    byte_off_d = byte_off_q;
    if (end_of_input_i) begin
      in_id_d    = 1'b0;
      id_len_d   = '0;
      id_line_d  = '0;
      id_col_d   = '0;
      id_off_d   = '0;
      cur_line_d = tlex_pkg::pos_t'(1);
      cur_col_d  = '0;
      byte_off_d = '0;
    end else begin
      if (alnum) begin
        in_id_d = 1'b1;
        if (in_id_q) begin
          id_len_d = tlex_pkg::sat_inc(id_len_q);
        end else begin
          id_len_d  = tlex_pkg::pos_t'(1);
          id_line_d = cur_line_q;
          id_col_d  = col;
          id_off_d  = byte_off_q;
        end
      end else begin
        in_id_d = 1'b0;
      end
      if (data_byte_i == tlex_pkg::CH_LF) begin
        cur_line_d = tlex_pkg::sat_inc(cur_line_q);
        cur_col_d  = '0;
      end else begin
        cur_col_d = col;
      end
      byte_off_d = byte_off_q + tlex_pkg::off_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_id_q    <= 1'b0;
      id_len_q   <= '0;
      id_line_q  <= '0;
      id_col_q   <= '0;
      id_off_q   <= '0;
      cur_line_q <= tlex_pkg::pos_t'(1);
      cur_col_q  <= '0;
      byte_off_q <= '0;
    end else if (take_i) begin
      in_id_q    <= in_id_d;
      id_len_q   <= id_len_d;
      id_line_q  <= id_line_d;
      id_col_q   <= id_col_d;
      id_off_q   <= id_off_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      byte_off_q <= byte_off_d;
    end
  end

endmodule

### rtl/tlex_fifo.sv
// Result queue: takes zero, one or two tokens per cycle, hands out one.
// Depends on tlex_pkg.
module tlex_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tlex_pkg::tok_pair_t  pair_i,
  input  logic                 pop_i,
  output tlex_pkg::token_t     head_o,
  output tlex_pkg::fifo_stat_t stat_o
);

  tlex_pkg::token_t mem_q [tlex_pkg::FIFO_DEPTH];

  logic [tlex_pkg::PTR_W-1:0] wr_q, wr_d, rd_q, rd_d, wr1;
  logic [tlex_pkg::CNT_W-1:0] cnt_q, cnt_d, n_in;
  logic                       do_pop;

  always_comb begin
    wr1    = wr_q + tlex_pkg::PTR_W'(1);
    n_in   = push_i ? tlex_pkg::CNT_W'(pair_i.count) : '0;
    do_pop = pop_i && (cnt_q != '0);
    wr_d   = wr_q + tlex_pkg::PTR_W'(n_in);
    rd_d   = do_pop ? rd_q + tlex_pkg::PTR_W'(1) : rd_q;
    cnt_d  = cnt_q + n_in - tlex_pkg::CNT_W'(do_pop);

    head_o       = mem_q[rd_q];
    stat_o.count = cnt_q;
    stat_o.room2 = (cnt_q <= tlex_pkg::CNT_W'(tlex_pkg::FIFO_DEPTH - 2));
  end

  always_ff @(posedge clk_i) begin
    if (push_i && pair_i.count != 2'd0) begin
      mem_q[wr_q] <= pair_i.tok0;
    end
    if (push_i && pair_i.count == 2'd2) begin
      mem_q[wr1] <= pair_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### bench/tlex_checker.sv
// Checker for token_lexer_top: watches both channels, predicts the tokens of
// each accepted byte and compares them in order. Depends on tlex_pkg.
module tlex_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  token_kind_i,
  input  logic [15:0] token_line_i,
  input  logic [15:0] token_column_i,
  input  logic [31:0] token_offset_i,
  input  logic [15:0] token_length_i,
  input  logic        last_result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned tokens_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlex_pkg::*;

  // lexer position and pending identifier
  logic in_ident;
  len_t id_len;
  pos_t id_line;
  pos_t id_col;
  off_t id_off;
  pos_t cur_line;
  pos_t cur_col;
  off_t cur_off;

  token_t      token_q[$];
  int unsigned fail_count;
  int unsigned tokens_checked;

  initial begin
    fail_count     = 0;
    tokens_checked = 0;
  end

  function automatic logic [15:0] saturate_up(logic [15:0] v);
    logic [16:0] sum;
    sum = {1'b0, v} + 17'd1;
    return sum[16] ? v : sum[15:0];
  endfunction

  task automatic clear_state();
    in_ident = 1'b0;
    id_len   = '0;
    id_line  = '0;
    id_col   = '0;
    id_off   = '0;
    cur_line = pos_t'(1);
    cur_col  = '0;
    cur_off  = '0;
  endtask

  task automatic push_token(kind_e k, pos_t ln, pos_t col, off_t off, len_t len);
    token_t t;
    t.kind   = k;
    t.line   = ln;
    t.column = col;
    t.offset = off;
    t.length = len;
    t.last   = 1'b0;
    token_q.push_back(t);
  endtask

  task automatic lex_item(byte_t b, logic eoi);
    token_t      t;
    pos_t        col;
    kind_e       k;
    logic        alnum;
    int unsigned n_prior;
    n_prior = token_q.size();
    col     = saturate_up(cur_col);
    alnum   = b inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ], [CH_D0:CH_D9]};
    if (eoi) begin
      if (in_ident) push_token(KIND_IDENT, id_line, id_col, id_off, id_len);
      push_token(KIND_EOF, cur_line, col, cur_off, len_t'(1));
      clear_state();
    end else begin
      // identifier ends on the first non-alnum byte, ahead of that byte's token
      if (in_ident && !alnum) begin
        push_token(KIND_IDENT, id_line, id_col, id_off, id_len);
        in_ident = 1'b0;
      end
      if (alnum) begin
        if (in_ident) begin
          id_len = saturate_up(id_len);
        end else begin
          in_ident = 1'b1;
          id_len   = len_t'(1);
          id_line  = cur_line;
          id_col   = col;
          id_off   = cur_off;
        end
      end else if (!(b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
        case (b)
          CH_LPAREN: k = KIND_LPAREN;
          CH_RPAREN: k = KIND_RPAREN;
          CH_LBRACE: k = KIND_LBRACE;
          CH_RBRACE: k = KIND_RBRACE;
          CH_COMMA:  k = KIND_COMMA;
          CH_SEMI:   k = KIND_SEMI;
          CH_PIPE:   k = KIND_PIPE;
          CH_EQUAL:  k = KIND_EQUAL;
          default:   k = KIND_ILLEGAL;
        endcase
        push_token(k, cur_line, col, cur_off, len_t'(1));
      end
      if (b == CH_LF) begin
        cur_line = saturate_up(cur_line);
        cur_col  = '0;
      end else begin
        cur_col = col;
      end
      cur_off = cur_off + off_t'(1);
    end
    if (token_q.size() > n_prior) begin
      t      = token_q.pop_back();
      t.last = 1'b1;
      token_q.push_back(t);
    end
  endtask

  task automatic report(string field, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_blk
    token_t exp_tok;
    if (!rst_ni) begin
      clear_state();
      token_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) lex_item(data_byte_i, end_of_input_i);
      if (out_valid_i && out_ready_i) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token, expected none, got kind %0d line %0d col %0d",
                   $time, token_kind_i, token_line_i, token_column_i);
          fail_count++;
        end else begin
          exp_tok = token_q.pop_front();
          tokens_checked++;
          report("kind",   32'(exp_tok.kind),   32'(token_kind_i));
          report("line",   32'(exp_tok.line),   32'(token_line_i));
          report("column", 32'(exp_tok.column), 32'(token_column_i));
          report("offset", 32'(exp_tok.offset), 32'(token_offset_i));
          report("length", 32'(exp_tok.length), 32'(token_length_i));
          report("last",   32'(exp_tok.last),   32'(last_result_i));
        end
      end
    end
    fail_count_o     <= fail_count;
    pending_o        <= token_q.size();
    tokens_checked_o <= tokens_checked;
  end

endmodule

### bench/tb_top.sv
// Top of the token lexer bench: clock, reset, byte stimulus, output stalls
// and the verdict. Depends on tlex_pkg, token_lexer_top and tlex_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tlex_pkg::*;

  localparam byte_t PUNCT_CHARS [8] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                        CH_COMMA, CH_SEMI, CH_PIPE, CH_EQUAL};
  localparam byte_t BLANK_CHARS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_input_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  token_kind_o;
  logic [15:0] token_line_o;
  logic [15:0] token_column_o;
  logic [31:0] token_offset_o;
  logic [15:0] token_length_o;
  logic        last_result_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned tokens_checked;

  logic        quiet;         // no idling on either side
  logic        hold_off_req;  // asks the receiver for one long stall
  int unsigned items_sent;
  int unsigned ends_sent;
  int unsigned rand_items;
  int unsigned pick;
  logic        held;
  logic        paused;

  token_lexer_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .token_line_o   (token_line_o),
    .token_column_o (token_column_o),
    .token_offset_o (token_offset_o),
    .token_length_o (token_length_o),
    .last_result_o  (last_result_o)
  );

  tlex_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_input_i   (end_of_input_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .token_kind_i     (token_kind_o),
    .token_line_i     (token_line_o),
    .token_column_i   (token_column_o),
    .token_offset_i   (token_offset_o),
    .token_length_i   (token_length_o),
    .last_result_i    (last_result_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .tokens_checked_o (tokens_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, a stall-free stretch and one long hold-off
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (quiet) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 32);
      end
    end
  end

  function automatic byte_t random_alnum();
    int unsigned r;
    r = $urandom_range(61);
    if (r < 26) return CH_LA + byte_t'(r);
    if (r < 52) return CH_UA + byte_t'(r - 26);
    return CH_D0 + byte_t'(r - 52);
  endfunction

  task automatic send_item(input byte_t b, input logic eoi);
    if (!quiet) begin
      while ($urandom_range(99) < 32) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (eoi) ends_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(byte_t'(s[i]), 1'b0);
  endtask

  // clock edge first so the checker has seen the last accepted item
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = '0;
    end_of_input_i = 1'b0;
    quiet          = 1'b0;
    hold_off_req   = 1'b0;
    items_sent     = 0;
    ends_sent      = 0;
    rand_items     = 0;
    held           = 1'b0;
    paused         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every punctuation kind, letter and digit bounds, blanks, identifier
    // flushed by a newline, NUL and high bytes, two tokens from one byte,
    // identifier flushed by end, then an end with nothing pending
    send_text("(){},;|=");
    send_text("azAZ09 ");
    send_item(CH_TAB, 1'b0);
    send_item(CH_CR, 1'b0);
    send_text("x\n");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("b(");
    send_text("q");
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
    wait_drained();

    // random text: mostly identifiers, punctuation and blanks
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= 500 && !held) begin
        hold_off_req = 1'b1;
        held         = 1'b1;
      end
      if (rand_items >= 1100 && !paused) begin
        wait_drained();
        paused = 1'b1;
      end
      quiet = (rand_items >= 1400 && rand_items < 1600);
      pick  = $urandom_range(99);
      if (pick < 40) begin
        repeat ($urandom_range(12, 1)) begin
          send_item(random_alnum(), 1'b0);
          rand_items++;
        end
      end else begin
        if (pick < 65)      send_item(PUNCT_CHARS[$urandom_range(7)], 1'b0);
        else if (pick < 85) send_item(BLANK_CHARS[$urandom_range(3)], 1'b0);
        else if (pick < 97) send_item(byte_t'($urandom), 1'b0);
        else                send_item(byte_t'($urandom), 1'b1);
        rand_items++;
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Run: %0d bytes sent (%0d end markers), %0d tokens compared.",
             items_sent, ends_sent, tokens_checked);
    $display("Covered all token kinds, blank and illegal bytes, two-token bytes, stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/tlex_pkg.sv
rtl/tlex_core.sv
rtl/tlex_fifo.sv
rtl/token_lexer_top.sv
bench/tlex_checker.sv
bench/tb_top.sv
